>>> design/ssfc_pkg.sv
package ssfc_pkg;

  // Header length default
  localparam int HEADER_LEN_DEF = 14;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 16;
  localparam int STATUS_W = 2;

  // Header offsets
  localparam logic [WORD_W-1:0] OFS_SUM_LO    = 16'h0006;
  localparam logic [WORD_W-1:0] OFS_SUM_HI    = 16'h0007;
  localparam logic [WORD_W-1:0] OFS_SUM_START = 16'h0008;
  localparam logic [WORD_W-1:0] OFS_LEN_LO    = 16'h000A;
  localparam logic [WORD_W-1:0] OFS_LEN_HI    = 16'h000B;
  localparam logic [WORD_W-1:0] POS_MAX       = 16'hFFFF;

  // Output packing
  localparam int OUT_DATA_W = 32;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_SUM_ERR   = 2'd2,
    ST_LEN_ERR   = 2'd3
  } status_t;

  // Per-frame tracking state
  typedef struct packed {
    logic [WORD_W-1:0] byte_position;
    logic [WORD_W-1:0] running_sum;
    logic [WORD_W-1:0] expected_sum;
    logic [WORD_W-1:0] declared_length;
  } frame_state_t;

  // One result item
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_valid;
    logic              frame_done;
    status_t           frame_status;
    logic [WORD_W-1:0] payload_length;
  } result_t;

endpackage

>>> design/ssfc_eval.sv
module ssfc_eval #(
  parameter int HEADER_LEN = ssfc_pkg::HEADER_LEN_DEF
) (
  input  ssfc_pkg::frame_state_t           state_cur,
  input  logic [ssfc_pkg::WORD_W-1:0]      seed,
  input  logic [ssfc_pkg::BYTE_W-1:0]      data_byte,
  input  logic                             last_byte,
  output ssfc_pkg::frame_state_t           state_nxt,
  output ssfc_pkg::result_t                result
);

  localparam logic [ssfc_pkg::WORD_W:0] HDR = (ssfc_pkg::WORD_W+1)'(HEADER_LEN);

  logic [ssfc_pkg::WORD_W-1:0] pos;
  logic [ssfc_pkg::WORD_W-1:0] exp_upd;
  logic [ssfc_pkg::WORD_W-1:0] len_upd;
  logic [ssfc_pkg::WORD_W-1:0] sum_upd;
  logic [ssfc_pkg::WORD_W-1:0] sum_cmp;
  logic [ssfc_pkg::WORD_W:0]   pay_end;
  logic [ssfc_pkg::WORD_W:0]   flen;
  logic                        in_payload;

  assign pos = state_cur.byte_position;

  // Capture checksum and length bytes from the header
  always_comb begin
    exp_upd = state_cur.expected_sum;
    len_upd = state_cur.declared_length;
    unique if (pos == ssfc_pkg::OFS_SUM_LO) begin
      exp_upd[7:0] = data_byte;
    end else if (pos == ssfc_pkg::OFS_SUM_HI) begin
      exp_upd[15:8] = data_byte;
    end else if (pos == ssfc_pkg::OFS_LEN_LO) begin
      len_upd[7:0] = data_byte;
    end else if (pos == ssfc_pkg::OFS_LEN_HI) begin
      len_upd[15:8] = data_byte;
    end else begin
      exp_upd = state_cur.expected_sum;
    end
  end

  // Seed the running sum at the first summed byte, then accumulate
  always_comb begin
    priority if (pos == ssfc_pkg::OFS_SUM_START) begin
      sum_upd = seed + ssfc_pkg::WORD_W'(data_byte);
    end else if (pos > ssfc_pkg::OFS_SUM_START) begin
      sum_upd = state_cur.running_sum + ssfc_pkg::WORD_W'(data_byte);
    end else begin
      sum_upd = state_cur.running_sum;
    end
  end

  assign pay_end    = HDR + {1'b0, len_upd};
  assign in_payload = ({1'b0, pos} >= HDR) && ({1'b0, pos} < pay_end);
  assign flen       = {1'b0, pos} + 17'd1;
  assign sum_cmp    = (pos >= ssfc_pkg::OFS_SUM_START) ? sum_upd : seed;

  // Build the result item
  always_comb begin
    result.payload_byte   = in_payload ? data_byte : '0;
    result.payload_valid  = in_payload;
    result.frame_done     = last_byte;
    result.payload_length = last_byte ? len_upd : '0;
    priority if (!last_byte) begin
      result.frame_status = ssfc_pkg::ST_OK;
    end else if (flen < HDR) begin
      result.frame_status = ssfc_pkg::ST_SHORT;
    end else if (sum_cmp != exp_upd) begin
      result.frame_status = ssfc_pkg::ST_SUM_ERR;
    end else if (pay_end > flen) begin
      result.frame_status = ssfc_pkg::ST_LEN_ERR;
    end else begin
      result.frame_status = ssfc_pkg::ST_OK;
    end
  end

  // Clear on the final byte, otherwise advance with saturation
  always_comb begin
    if (last_byte) begin
      state_nxt = '0;
    end else begin
      state_nxt.byte_position   = (pos == ssfc_pkg::POS_MAX) ? pos : pos + 16'd1;
      state_nxt.running_sum     = sum_upd;
      state_nxt.expected_sum    = exp_upd;
      state_nxt.declared_length = len_upd;
    end
  end

endmodule

>>> design/seeded_sum_frame_checker.sv
// Seeded-sum frame checker.
// Input stream in_*: one frame byte per transfer in in_tdata, in_tlast on the
// final byte. Checksum (LE) sits at offsets 6-7, payload length (LE) at 10-11;
// bytes from offset 8 on are summed into a 16-bit wrapping sum that starts at
// the seed written over cfg_*. cfg_ready is always high.
// Output stream out_*: exactly one transfer per input byte. out_tuser flags a
// payload byte (offset HEADER_LEN up to HEADER_LEN + length); payload leaves
// before the frame is verified, so the consumer drops it unless the status on
// the out_tlast transfer is ok.
// Timing: the result is registered and appears in the cycle after the input transfer.
// Throughput: one byte per cycle when not stalled; the byte position, sum and
// compare are evaluated in one pass between frame state and output register.
// Stall: in_tready follows out_tready while a result is held; when the
// output register is empty a byte is taken even if out_tready is low.
// Reset: the seed and all frame state clear to zero, the output register
// empties.
module seeded_sum_frame_checker #(
  parameter int HEADER_LEN = ssfc_pkg::HEADER_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ssfc_pkg::WORD_W-1:0]       cfg_data,      // checksum_seed
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ssfc_pkg::BYTE_W-1:0]       in_tdata,      // [7:0] data_byte
  input  logic                              in_tlast,      // last_byte
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] payload_byte, [9:8] frame_status, [25:10] payload_length, rest 0
  output logic [ssfc_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tuser,     // payload_valid
  output logic                              out_tlast      // frame_done
);

  logic [ssfc_pkg::WORD_W-1:0] seed_r;
  ssfc_pkg::frame_state_t      state_r;
  ssfc_pkg::frame_state_t      state_nxt;
  ssfc_pkg::result_t           res_nxt;
  ssfc_pkg::result_t           res_r;
  logic                        out_valid_r;
  logic                        in_xfer;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  ssfc_eval #(
    .HEADER_LEN (HEADER_LEN)
  ) u_eval (
    .state_cur (state_r),
    .seed      (seed_r),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  // Hold the seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      seed_r <= cfg_data;
    end
  end

  // Advance frame state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  // Output register: load on input transfer, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.payload_valid;
  assign out_tlast  = res_r.frame_done;
  assign out_tdata  = {6'd0, res_r.payload_length, res_r.frame_status, res_r.payload_byte};

endmodule

>>> design/ssfc_checker.sv
module ssfc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [ssfc_pkg::WORD_W-1:0]     cfg_data,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [ssfc_pkg::BYTE_W-1:0]     in_tdata,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ssfc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast
);

  // Non-payload results carry a zero byte
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[7:0] == 8'd0))
    else $error("non-payload result with nonzero byte");

  // Status and length only on the frame's final result
  a_mid_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[25:8] == 18'd0))
    else $error("status or length outside final result");

  // Input side is open whenever the output side can drain
  a_ready_open: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled with room at the output");

  // A byte taken always yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("accepted byte produced no result");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind seeded_sum_frame_checker ssfc_checker u_ssfc_checker (.*);

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int HDR = ssfc_pkg::HEADER_LEN_DEF;
  localparam int QUIET_LIMIT = 1000;

  // One byte waiting to go into the checker
  typedef struct packed {
    logic [ssfc_pkg::BYTE_W-1:0] data;
    logic                        last;
    logic                        wait_idle;  // hold until every result is back
  } feed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [ssfc_pkg::WORD_W-1:0]     cfg_data = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [ssfc_pkg::BYTE_W-1:0]     in_tdata = '0;   // [7:0] data_byte
  logic                            in_tlast = 1'b0; // last_byte
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // [7:0] payload_byte, [9:8] frame_status, [25:10] payload_length, rest 0
  logic [ssfc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tuser;       // payload_valid
  logic                            out_tlast;       // frame_done

  // Stimulus and expected results
  feed_t               byte_feed[$];
  ssfc_pkg::result_t   due_results[$];
  feed_t               cur_byte;
  ssfc_pkg::result_t   want;
  int                  fed_total;
  logic [ssfc_pkg::WORD_W-1:0] cur_seed = '0;
  bit        in_burst = 1'b0;
  bit        out_burst = 1'b0;

  // Handshake bookkeeping
  logic      in_took = 1'b0;
  logic      out_took = 1'b0;
  int        in_wait = 0;
  int        out_stall = 0;
  int        draw_stall;
  int        quiet = 0;
  int        errors = 0;

  // Predicted checker state
  logic [ssfc_pkg::WORD_W-1:0] m_seed = '0;
  logic [ssfc_pkg::WORD_W-1:0] m_pos = '0;
  logic [ssfc_pkg::WORD_W-1:0] m_sum = '0;
  logic [ssfc_pkg::WORD_W-1:0] m_csum = '0;
  logic [ssfc_pkg::WORD_W-1:0] m_len = '0;

  always #5 clk = ~clk;

  seeded_sum_frame_checker #(.HEADER_LEN(HDR)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // Advance the predicted frame state by one byte and return its result
  function automatic ssfc_pkg::result_t frame_byte_result(
      input logic [ssfc_pkg::BYTE_W-1:0] b, input logic last);
    ssfc_pkg::result_t           r;
    int unsigned                 flen;
    logic [ssfc_pkg::WORD_W-1:0] sum_now;
    r = '0;
    if (m_pos == ssfc_pkg::OFS_SUM_LO) m_csum[7:0] = b;
    else if (m_pos == ssfc_pkg::OFS_SUM_HI) m_csum[15:8] = b;
    else if (m_pos == ssfc_pkg::OFS_LEN_LO) m_len[7:0] = b;
    else if (m_pos == ssfc_pkg::OFS_LEN_HI) m_len[15:8] = b;

    if (m_pos == ssfc_pkg::OFS_SUM_START) m_sum = m_seed + b;
    else if (m_pos > ssfc_pkg::OFS_SUM_START) m_sum = m_sum + b;

    r.payload_valid = (m_pos >= HDR) && ({16'd0, m_pos} < HDR + {16'd0, m_len});
    if (r.payload_valid) r.payload_byte = b;

    if (last) begin
      flen = m_pos + 1;
      sum_now = (m_pos >= ssfc_pkg::OFS_SUM_START) ? m_sum : m_seed;
      r.frame_done = 1'b1;
      r.payload_length = m_len;
      if (flen < HDR) r.frame_status = ssfc_pkg::ST_SHORT;
      else if (sum_now != m_csum) r.frame_status = ssfc_pkg::ST_SUM_ERR;
      else if (HDR + {16'd0, m_len} > flen) r.frame_status = ssfc_pkg::ST_LEN_ERR;
      else r.frame_status = ssfc_pkg::ST_OK;
      m_pos = '0;
      m_sum = '0;
      m_csum = '0;
      m_len = '0;
    end else if (m_pos != ssfc_pkg::POS_MAX) begin
      m_pos = m_pos + 1'b1;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      errors++;
    end
  endfunction

  // Sample transfers, predict, compare, watch for a hang
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took <= in_tvalid && in_tready;
      out_took <= out_tvalid && out_tready;
      if (cfg_valid && cfg_ready) m_seed = cfg_data;
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $error("result transfer with nothing expected: tdata 0x%0h", out_tdata);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("payload_byte", 32'(want.payload_byte), 32'(out_tdata[7:0]));
          check_field("frame_status", 32'(want.frame_status), 32'(out_tdata[9:8]));
          check_field("payload_length", 32'(want.payload_length), 32'(out_tdata[25:10]));
          check_field("tdata_pad", 32'd0, 32'(out_tdata[31:26]));
          check_field("payload_valid", 32'(want.payload_valid), 32'(out_tuser));
          check_field("frame_done", 32'(want.frame_done), 32'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) due_results.push_back(frame_byte_result(in_tdata, in_tlast));

      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Drive input bytes from the feed queue with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_took) begin
      // hold the byte until its transfer
    end else if (in_wait > 0) begin
      in_tvalid <= 1'b0;
      in_wait <= in_wait - 1;
    end else if (byte_feed.size() > 0 &&
                 !(byte_feed[0].wait_idle && due_results.size() != 0)) begin
      cur_byte = byte_feed.pop_front();
      in_tdata <= cur_byte.data;
      in_tlast <= cur_byte.last;
      in_tvalid <= 1'b1;
      in_wait <= in_burst ? 0 : $urandom_range(0, 14);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Stall the result side for a random number of cycles per transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_took) begin
      draw_stall = out_burst ? 0 : $urandom_range(0, 14);
      out_tready <= (draw_stall == 0);
      out_stall <= (draw_stall == 0) ? 0 : draw_stall - 1;
    end else if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Build one frame; fill < 0 means random bytes
  task automatic queue_frame(input int nbytes, input logic [ssfc_pkg::WORD_W-1:0] plen,
                             input bit fix_sum, input bit wait_idle, input int fill);
    logic [ssfc_pkg::BYTE_W-1:0] fr[$];
    logic [ssfc_pkg::WORD_W-1:0] s;
    feed_t                       f;
    for (int i = 0; i < nbytes; i++)
      fr.push_back(ssfc_pkg::BYTE_W'(fill < 0 ? $urandom_range(0, 255) : fill));
    if (nbytes > ssfc_pkg::OFS_LEN_LO) fr[ssfc_pkg::OFS_LEN_LO] = plen[7:0];
    if (nbytes > ssfc_pkg::OFS_LEN_HI) fr[ssfc_pkg::OFS_LEN_HI] = plen[15:8];
    if (fix_sum && nbytes >= ssfc_pkg::OFS_SUM_START) begin
      s = cur_seed;
      for (int i = ssfc_pkg::OFS_SUM_START; i < nbytes; i++) s = s + fr[i];
      fr[ssfc_pkg::OFS_SUM_LO] = s[7:0];
      fr[ssfc_pkg::OFS_SUM_HI] = s[15:8];
    end
    for (int i = 0; i < nbytes; i++) begin
      f.data = fr[i];
      f.last = (i == nbytes - 1);
      f.wait_idle = wait_idle && (i == 0);
      byte_feed.push_back(f);
    end
    fed_total += nbytes;
  endtask

  // Mostly well-formed frames, plus each kind of broken one and noise
  task automatic queue_random_frame();
    int kind;
    int n;
    bit pause;
    kind = $urandom_range(0, 9);
    pause = ($urandom_range(0, 19) == 0);
    n = $urandom_range(HDR, HDR + 24);
    if (kind < 6) begin
      queue_frame(n, 16'($urandom_range(0, n - HDR)), 1'b1, pause, -1);
    end else if (kind == 6) begin
      queue_frame(n, 16'($urandom_range(0, n - HDR)), 1'b0, pause, -1);
    end else if (kind == 7) begin
      queue_frame(n, 16'($urandom_range(n - HDR + 1,
                  ($urandom_range(0, 3) == 0) ? 16'hFFFF : n - HDR + 8)), 1'b1, pause, -1);
    end else if (kind == 8) begin
      queue_frame($urandom_range(1, HDR - 1), 16'($urandom), $urandom_range(0, 1), pause, -1);
    end else begin
      queue_frame($urandom_range(1, 40), 16'($urandom), 1'b0, pause, -1);
    end
  endtask

  // Wait until every byte is in and every result is out
  task automatic settle();
    @(posedge clk);
    while (byte_feed.size() != 0 || in_tvalid || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_seed(input logic [ssfc_pkg::WORD_W-1:0] v);
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    cur_seed = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_frames(input int goal, input bit burst_in, input bit burst_out);
    in_burst = burst_in;
    out_burst = burst_out;
    fed_total = 0;
    while (fed_total < goal) queue_random_frame();
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset seed: one-byte frame, empty payload at minimum length, short frame
    queue_frame(1, 16'h0000, 1'b0, 1'b0, 8'hFF);
    queue_frame(HDR, 16'h0000, 1'b1, 1'b0, 8'h00);
    queue_frame(10, 16'hFFFF, 1'b0, 1'b1, 8'hFF);
    settle();

    write_seed(16'hFFFF);
    run_frames(400, 1'b0, 1'b0);
    write_seed(16'($urandom));
    run_frames(300, 1'b1, 1'b1);
    write_seed(16'h0000);
    run_frames(200, 1'b1, 1'b0);
    write_seed(16'($urandom));
    run_frames(200, 1'b0, 1'b1);
    write_seed(16'($urandom));
    run_frames(300, 1'b0, 1'b0);

    repeat (5) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
